// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check that the antecedent in one cycle implies the consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// check that the antecedent in one cycle implies the consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/idl_pkg.sv =====
package idl_pkg;

   localparam int LIST_CAPACITY_DEF = 'h200;
   localparam int FLAG_COUNT_DEF    = 'h200;

   localparam int ID_W     = 16;
   localparam int OP_W     = 3;
   localparam int SLOT_W   = 10;
   localparam int LENGTH_W = 10;

   typedef enum logic [OP_W-1:0] {
      OP_ADD      = 3'd0,
      OP_CONTAINS = 3'd1,
      OP_POSITION = 3'd2,
      OP_READ     = 3'd3,
      OP_TEST     = 3'd4,
      OP_MARK     = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SEARCH,
      ST_WAIT,
      ST_RESP
   } state_type;

   typedef enum logic [2:0] {
      RES_NONE,
      RES_OK,
      RES_SLOT,
      RES_FLAG,
      RES_POS
   } res_sel_type;

   typedef struct packed {
      logic [OP_W-1:0]   req_type;
      logic [ID_W-1:0]   item_id;
      logic [SLOT_W-1:0] slot_index;
   } req_payload_type;

   typedef struct packed {
      logic                success;
      logic [ID_W-1:0]     result_value;
      logic [LENGTH_W-1:0] list_length;
   } rsp_payload_type;

   typedef struct packed {
      logic        clear_step;
      logic        capture;
      logic        add;
      logic        mark;
      logic        search_start;
      logic        search_step;
      logic        rd_slot;
      logic        res_load;
      res_sel_type res_sel;
      logic        push;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            id_lt_def;
      logic            id_lt_flag;
      logic            slot_lt_cnt;
      logic            list_full;
      logic            hit;
      logic            scan_done;
      logic            clear_done;
      logic            rsp_free;
   } stat_type;

endpackage

// ===== rtl/idl_chan_if.sv =====
interface idl_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/idl_ram.sv =====
module idl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== rtl/idl_ctrl.sv =====
module idl_ctrl import idl_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   input  logic     req_valid,
   output logic     req_ready,
   output cmd_type  cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.res_sel = RES_NONE;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in     = ST_RESP;
            cmd.res_load = 1'b1;
            case (stat.op)
               OP_ADD: begin
                  if (stat.id_lt_def && !stat.list_full) begin
                     cmd.add     = 1'b1;
                     cmd.res_sel = RES_OK;
                  end
               end
               OP_CONTAINS: begin
                  if (stat.id_lt_def) begin
                     cmd.res_load     = 1'b0;
                     cmd.search_start = 1'b1;
                     state_in         = ST_SEARCH;
                  end
               end
               OP_POSITION: begin
                  cmd.res_load     = 1'b0;
                  cmd.search_start = 1'b1;
                  state_in         = ST_SEARCH;
               end
               OP_READ: begin
                  if (stat.slot_lt_cnt) begin
                     cmd.res_load = 1'b0;
                     cmd.rd_slot  = 1'b1;
                     state_in     = ST_WAIT;
                  end
               end
               OP_TEST: begin
                  if (stat.id_lt_flag) begin
                     cmd.res_load = 1'b0;
                     state_in     = ST_WAIT;
                  end
               end
               OP_MARK: begin
                  if (stat.id_lt_flag) begin
                     cmd.mark    = 1'b1;
                     cmd.res_sel = RES_OK;
                  end
               end
               default: begin
                  cmd.res_sel = RES_NONE;
               end
            endcase
         end
         ST_SEARCH: begin
            cmd.search_step = 1'b1;
            if (stat.hit) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = (stat.op == OP_POSITION) ? RES_POS : RES_OK;
               state_in     = ST_RESP;
            end else if (stat.scan_done) begin
               cmd.res_load = 1'b1;
               state_in     = ST_RESP;
            end
         end
         ST_WAIT: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = (stat.op == OP_READ) ? RES_SLOT : RES_FLAG;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            if (stat.rsp_free) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

// ===== rtl/idl_dpath.sv =====
module idl_dpath import idl_pkg::*; #(
   parameter int LIST_CAPACITY = LIST_CAPACITY_DEF,
   parameter int FLAG_COUNT    = FLAG_COUNT_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   output stat_type        stat,
   input  req_payload_type req_data,
   input  logic            csr_wr,
   input  logic [ID_W-1:0] csr_data,
   input  logic            rsp_ready,
   output logic            rsp_valid,
   output rsp_payload_type rsp_data
);
   localparam int AW = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
   localparam int CW = $clog2(LIST_CAPACITY + 1);
   localparam int FA = $clog2(FLAG_COUNT);

   logic [OP_W-1:0]   op_ff, op_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [ID_W-1:0]   def_ff, def_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [FA-1:0]     clr_ff, clr_in;
   logic [CW-1:0]     scan_ff, scan_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     pidx_ff, pidx_in;
   logic              res_ok_ff, res_ok_in;
   logic [ID_W-1:0]   res_val_ff, res_val_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_ff, rsp_in;

   logic              id_we;
   logic [AW-1:0]     id_raddr;
   logic [ID_W-1:0]   id_rdata;
   logic              flag_we;
   logic [FA-1:0]     flag_waddr;
   logic              flag_wdata;
   logic              flag_rdata;
   logic              scan_more;

   idl_ram #(.WIDTH(ID_W), .DEPTH(LIST_CAPACITY)) u_id_ram (
      .clock (clock),
      .we    (id_we),
      .waddr (count_ff[AW-1:0]),
      .wdata (id_ff),
      .raddr (id_raddr),
      .rdata (id_rdata)
   );

   idl_ram #(.WIDTH(1), .DEPTH(FLAG_COUNT)) u_flag_ram (
      .clock (clock),
      .we    (flag_we),
      .waddr (flag_waddr),
      .wdata (flag_wdata),
      .raddr (id_ff[FA-1:0]),
      .rdata (flag_rdata)
   );

   assign scan_more = scan_ff < count_ff;
   assign id_we     = cmd.add;
   assign id_raddr  = cmd.rd_slot ? AW'(slot_ff) : scan_ff[AW-1:0];

   always_comb begin
      flag_we    = 1'b0;
      flag_waddr = id_ff[FA-1:0];
      flag_wdata = 1'b0;
      if (cmd.clear_step) begin
         flag_we    = 1'b1;
         flag_waddr = clr_ff;
      end else if (cmd.add && stat.id_lt_flag) begin
         flag_we = 1'b1;
      end else if (cmd.mark) begin
         flag_we    = 1'b1;
         flag_wdata = 1'b1;
      end
   end

   always_comb begin
      stat.op          = op_ff;
      stat.id_lt_def   = id_ff < def_ff;
      stat.id_lt_flag  = {16'd0, id_ff} < 32'(FLAG_COUNT);
      stat.slot_lt_cnt = 32'(slot_ff) < 32'(count_ff);
      stat.list_full   = count_ff == CW'(LIST_CAPACITY);
      stat.hit         = pend_ff && (id_rdata == id_ff);
      stat.scan_done   = !pend_ff && !scan_more;
      stat.clear_done  = clr_ff == FA'(FLAG_COUNT - 1);
      stat.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      op_in        = cmd.capture ? req_data.req_type : op_ff;
      id_in        = cmd.capture ? req_data.item_id : id_ff;
      slot_in      = cmd.capture ? req_data.slot_index : slot_ff;
      def_in       = csr_wr ? csr_data : def_ff;
      count_in     = cmd.add ? count_ff + CW'(1) : count_ff;
      clr_in       = cmd.clear_step ? clr_ff + FA'(1) : clr_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      pidx_in      = pidx_ff;
      res_ok_in    = res_ok_ff;
      res_val_in   = res_val_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (cmd.search_start) begin
         scan_in = '0;
         pend_in = 1'b0;
      end else if (cmd.search_step) begin
         pend_in = scan_more;
         if (scan_more) begin
            scan_in = scan_ff + CW'(1);
            pidx_in = scan_ff[AW-1:0];
         end
      end

      if (cmd.res_load) begin
         case (cmd.res_sel)
            RES_OK: begin
               res_ok_in  = 1'b1;
               res_val_in = '0;
            end
            RES_SLOT: begin
               res_ok_in  = 1'b1;
               res_val_in = id_rdata;
            end
            RES_FLAG: begin
               res_ok_in  = flag_rdata;
               res_val_in = '0;
            end
            RES_POS: begin
               res_ok_in  = 1'b1;
               res_val_in = ID_W'(pidx_ff) + ID_W'(1);
            end
            default: begin
               res_ok_in  = 1'b0;
               res_val_in = '0;
            end
         endcase
      end

      if (cmd.push) begin
         rsp_valid_in        = 1'b1;
         rsp_in.success      = res_ok_ff;
         rsp_in.result_value = res_val_ff;
         rsp_in.list_length  = LENGTH_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         def_ff       <= '0;
         count_ff     <= '0;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         def_ff       <= def_in;
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      id_ff      <= id_in;
      slot_ff    <= slot_in;
      scan_ff    <= scan_in;
      pidx_ff    <= pidx_in;
      res_ok_ff  <= res_ok_in;
      res_val_ff <= res_val_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

// ===== rtl/id_list_with_received_bitmap.sv =====
// Accepted add and mark, unused codes and rejected requests go from execution straight to the
// result; an accepted read slot or test first waits for a memory read, and contains and position
// scan the list. One item is handled at a time; searches compare one stored entry per cycle.
// The result register frees the input side while a result waits to be taken.
// Reset (synchronous, active high) clears the list length and the ID limit, then a clearing
// pass zeroes every received flag before the first item is accepted.
`include "assert_macros.svh"

module id_list_with_received_bitmap import idl_pkg::*; #(
   parameter int LIST_CAPACITY = LIST_CAPACITY_DEF,
   parameter int FLAG_COUNT    = FLAG_COUNT_DEF
) (
   input logic        clock,
   input logic        reset,
   idl_chan_if.sink   req_chan,
   idl_chan_if.source rsp_chan,
   idl_chan_if.sink   csr_chan
);
   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;
   logic     csr_wr;

   assign csr_chan.ready = 1'b1;
   assign csr_wr         = csr_chan.valid && csr_chan.ready;
   assign req_chan.ready = req_ready;

   idl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   idl_dpath #(
      .LIST_CAPACITY (LIST_CAPACITY),
      .FLAG_COUNT    (FLAG_COUNT)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_chan.data),
      .csr_wr    (csr_wr),
      .csr_data  (csr_chan.data),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_data  (rsp_chan.data)
   );

   `ASSERT_IMPLIES(a_add, clock, reset, cmd.add, stat.id_lt_def && !stat.list_full, "bad add")
   `ASSERT_IMPLIES(a_push_free, clock, reset, cmd.push, stat.rsp_free, "result overwritten")
   `ASSERT_NEXT(a_one_item, clock, reset, req_chan.valid && req_ready, !req_ready, "overlap")
endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import idl_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
   localparam int unsigned CYCLE_LIMIT = 4_000_000;

   typedef struct {
      bit                  is_write;
      logic [OP_W-1:0]     op;
      logic [ID_W-1:0]     id;
      logic [SLOT_W-1:0]   slot;
      bit                  typed;
      rsp_payload_type     rsp;
   } plan_row_type;

   logic clock;
   logic reset;

   idl_chan_if #(.payload_type(req_payload_type)) req_if ();
   idl_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();
   idl_chan_if #(.payload_type(logic [ID_W-1:0])) csr_if ();

   id_list_with_received_bitmap DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if.sink),
      .rsp_chan(rsp_if.source),
      .csr_chan(csr_if.sink)
   );

   logic [ID_W-1:0]         id_list [LIST_CAPACITY_DEF];
   int unsigned             list_len = 0;
   bit [FLAG_COUNT_DEF-1:0] rx_flags = '0;
   logic [ID_W-1:0]         id_limit = '0;

   rsp_payload_type pending_rsp_q[$];
   plan_row_type    plan[$];
   int              errors = 0;
   int unsigned     cycles = 0;
   int              gap_pct = 0;
   int              stall_pct = 0;
   bit              typed_pending;
   rsp_payload_type typed_rsp;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_payload_type apply_request(req_payload_type r);
      rsp_payload_type o;
      int unsigned     hit_at;
      int unsigned     i;
      o = '0;
      hit_at = list_len;
      for (i = 0; i < list_len; i++) begin
         if (id_list[i] == r.item_id && hit_at == list_len) hit_at = i;
      end
      case (r.req_type)
         OP_ADD: begin
            if (r.item_id < id_limit && list_len < LIST_CAPACITY_DEF) begin
               id_list[list_len] = r.item_id;
               list_len++;
               if (r.item_id < FLAG_COUNT_DEF) rx_flags[r.item_id] = 1'b0;
               o.success = 1'b1;
            end
         end
         OP_CONTAINS: begin
            if (r.item_id < id_limit && hit_at < list_len) o.success = 1'b1;
         end
         OP_POSITION: begin
            if (hit_at < list_len) begin
               o.success = 1'b1;
               o.result_value = ID_W'(hit_at + 1);
            end
         end
         OP_READ: begin
            if (r.slot_index < list_len) begin
               o.success = 1'b1;
               o.result_value = id_list[r.slot_index];
            end
         end
         OP_TEST: begin
            if (r.item_id < FLAG_COUNT_DEF) begin
               if (rx_flags[r.item_id]) o.success = 1'b1;
            end
         end
         OP_MARK: begin
            if (r.item_id < FLAG_COUNT_DEF) begin
               rx_flags[r.item_id] = 1'b1;
               o.success = 1'b1;
            end
         end
         default: ;
      endcase
      o.list_length = LENGTH_W'(list_len);
      return o;
   endfunction

   task automatic flag_mismatch(string field, int unsigned want_v, int unsigned got_v);
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want_v, got_v);
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_rsp_q.size() == 0) begin
               errors++;
               $display("%0t: result with nothing pending: expected none actual %p",
                        $time, rsp_if.data);
            end else begin
               want = pending_rsp_q.pop_front();
               if (rsp_if.data.success !== want.success)
                  flag_mismatch("success", want.success, rsp_if.data.success);
               if (rsp_if.data.result_value !== want.result_value)
                  flag_mismatch("result_value", want.result_value, rsp_if.data.result_value);
               if (rsp_if.data.list_length !== want.list_length)
                  flag_mismatch("list_length", want.list_length, rsp_if.data.list_length);
            end
         end
         if (csr_if.valid && csr_if.ready) id_limit = csr_if.data;
         if (req_if.valid && req_if.ready) begin
            want = apply_request(req_if.data);
            pending_rsp_q.push_back(typed_pending ? typed_rsp : want);
         end
      end
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready = (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                               logic [SLOT_W-1:0] slot, bit typed,
                               rsp_payload_type typed_value);
      req_payload_type p;
      while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      p.req_type = op;
      p.item_id = id;
      p.slot_index = slot;
      req_if.data = p;
      typed_pending = typed;
      typed_rsp = typed_value;
      req_if.valid = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // hold off until every pending result is back
   task automatic drain();
      req_if.valid = 1'b0;
      while (pending_rsp_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_limit(logic [ID_W-1:0] value);
      csr_if.data = value;
      csr_if.valid = 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   function automatic void note(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                logic [SLOT_W-1:0] slot, int ok = -1, int val = 0,
                                int len = 0);
      plan_row_type row;
      row.is_write = 1'b0;
      row.op = op;
      row.id = id;
      row.slot = slot;
      row.typed = (ok >= 0);
      row.rsp.success = ok[0];
      row.rsp.result_value = ID_W'(val);
      row.rsp.list_length = LENGTH_W'(len);
      plan.push_back(row);
   endfunction

   function automatic void note_limit(logic [ID_W-1:0] value);
      plan_row_type row;
      row.is_write = 1'b1;
      row.op = OP_ADD;
      row.id = value;
      row.slot = '0;
      row.typed = 1'b0;
      row.rsp = '0;
      plan.push_back(row);
   endfunction

   task automatic random_request(int add_pct);
      logic [OP_W-1:0]   op;
      logic [ID_W-1:0]   id;
      logic [SLOT_W-1:0] slot;
      int                r;
      r = $urandom_range(99);
      if (r < add_pct) op = OP_ADD;
      else begin
         r = $urandom_range(99);
         if (r < 20) op = OP_CONTAINS;
         else if (r < 40) op = OP_POSITION;
         else if (r < 60) op = OP_READ;
         else if (r < 77) op = OP_TEST;
         else if (r < 94) op = OP_MARK;
         else op = r[0] ? OP_SPARE_A : OP_SPARE_B;
      end
      r = $urandom_range(99);
      if (r < 35 && list_len > 0) id = id_list[$urandom_range(list_len - 1)];
      else if (r < 60 && id_limit > 0) id = ID_W'($urandom_range(id_limit - 1));
      else if (r < 75) id = ID_W'($urandom_range(FLAG_COUNT_DEF - 1));
      else if (r < 85) begin
         case ($urandom_range(3))
            0: id = id_limit;
            1: id = id_limit - 1'b1;
            2: id = ID_W'(FLAG_COUNT_DEF - 1);
            default: id = ID_W'(FLAG_COUNT_DEF);
         endcase
      end else id = ID_W'($urandom());
      r = $urandom_range(99);
      if (r < 60) slot = SLOT_W'($urandom_range(list_len));
      else if (r < 75) slot = SLOT_W'(list_len - 1);
      else slot = SLOT_W'($urandom());
      send_request(op, id, slot, 1'b0, '0);
   endtask

   task automatic run_phase(int gap, int stall, logic [ID_W-1:0] limit, int add_pct,
                            int count, bit fill);
      int sent;
      int past_full;
      drain();
      write_limit(limit);
      gap_pct = gap;
      stall_pct = stall;
      sent = 0;
      past_full = 0;
      while (fill ? past_full < count : sent < count) begin
         random_request(add_pct);
         sent++;
         if (list_len >= LIST_CAPACITY_DEF) past_full++;
      end
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data = '0;
      csr_if.valid = 1'b0;
      csr_if.data = '0;
      typed_pending = 1'b0;
      typed_rsp = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      note(OP_ADD, 16'd0, 10'd0, 0, 0, 0);
      note(OP_CONTAINS, 16'd0, 10'd0, 0, 0, 0);
      note(OP_POSITION, 16'd0, 10'd0, 0, 0, 0);
      note(OP_READ, 16'd0, 10'd0, 0, 0, 0);
      note(OP_TEST, 16'd0, 10'd0, 0, 0, 0);
      note(OP_MARK, 16'd511, 10'd0, 1, 0, 0);
      note(OP_TEST, 16'd511, 10'd0, 1, 0, 0);
      note(OP_MARK, 16'd512, 10'd0, 0, 0, 0);
      note(OP_SPARE_A, 16'd0, 10'd0, 0, 0, 0);
      note(OP_SPARE_B, 16'hFFFF, 10'h3FF, 0, 0, 0);
      note_limit(16'hFFFF);
      note(OP_ADD, 16'hFFFE, 10'd0, 1, 0, 1);
      note(OP_ADD, 16'hFFFF, 10'd0, 0, 0, 1);
      note(OP_ADD, 16'd511, 10'd0, 1, 0, 2);
      note(OP_TEST, 16'd511, 10'd0, 0, 0, 2);
      note(OP_ADD, 16'd0, 10'd0, 1, 0, 3);
      note(OP_ADD, 16'd511, 10'd0, 1, 0, 4);
      note(OP_POSITION, 16'd511, 10'd0, 1, 2, 4);
      note(OP_CONTAINS, 16'hFFFE, 10'd0, 1, 0, 4);
      note(OP_POSITION, 16'hFFFF, 10'd0, 0, 0, 4);
      note(OP_READ, 16'd0, 10'd3, 1, 511, 4);
      note(OP_READ, 16'd0, 10'd4, 0, 0, 4);
      note(OP_MARK, 16'd0, 10'd0);
      note(OP_TEST, 16'd0, 10'd0);
      note_limit(16'd1);
      note(OP_CONTAINS, 16'hFFFE, 10'd0, 0, 0, 4);
      note(OP_POSITION, 16'hFFFE, 10'd0, 1, 1, 4);
      note(OP_CONTAINS, 16'd0, 10'd0, 1, 0, 4);

      foreach (plan[k]) begin
         if (plan[k].is_write) begin
            drain();
            write_limit(plan[k].id);
         end else
            send_request(plan[k].op, plan[k].id, plan[k].slot, plan[k].typed, plan[k].rsp);
      end

      run_phase(0, 0, 16'd16, 40, 300, 1'b0);
      run_phase(62, 0, 16'd512, 40, 300, 1'b0);
      run_phase(0, 62, ID_W'($urandom_range(65535, 1)), 50, 300, 1'b0);
      run_phase(9, 9, 16'hFFFF, 70, 100, 1'b1);

      drain();
      repeat (20) @(negedge clock);
      if (errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
